FILE: rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and codes of the LED current regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

	localparam logic [1:0] OP_SAMPLE   = 2'd0;
	localparam logic [1:0] OP_INCREASE = 2'd1;
	localparam logic [1:0] OP_DECREASE = 2'd2;

	localparam logic [2:0] CFG_DUTY_LIMIT        = 3'd0;
	localparam logic [2:0] CFG_SOFT_START_GAP    = 3'd1;
	localparam logic [2:0] CFG_LOW_CURRENT_LEVEL = 3'd2;
	localparam logic [2:0] CFG_SOFT_START_LENGTH = 3'd3;
	localparam logic [2:0] CFG_TARGET_LIMIT      = 3'd4;

	localparam logic [7:0] RST_DUTY_LIMIT        = 8'hFF - 8'h87;
	localparam logic [7:0] RST_SOFT_START_GAP    = 8'h10;
	localparam logic [7:0] RST_LOW_CURRENT_LEVEL = 8'h20;
	localparam logic [7:0] RST_SOFT_START_LENGTH = 8'hFF;
	localparam logic [7:0] RST_TARGET_LIMIT      = 8'hFE;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] sample;
	} cmd_t;

	typedef struct packed {
		logic [7:0] duty;
		logic [7:0] target;
		logic [7:0] current_average;
		logic [7:0] voltage_average;
		logic       target_changed;
		logic       sample_was_voltage;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/led_current_regulator.sv
// ----------------------------------------------------------------------------
// led_current_regulator
// LED current regulator: sample averaging, duty stepping, soft start and
// target buttons.
//
//   channel  signals                         transfer when
//   -------  ------------------------------  -------------------
//   cmd      cmd_valid cmd_stall cmd         valid && !stall
//   res      res_valid res_stall res         valid && !stall
//   cfg      cfg_valid cfg_ready cfg_index   valid && ready
//            cfg_data
//
// One item per cycle unless the pipe is held; each result passes through
// history and running sum, reciprocal multiply for the mean, and regulation.
// The three stages advance together; res_stall with a full result
// register holds the whole pipe and raises cmd_stall.
// Reset clears histories, sums and means and sets duty and target to one.
// ----------------------------------------------------------------------------
`default_nettype none

module led_current_regulator #(
	parameter int HISTORY_DEPTH = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire lcr_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output lcr_pkg::res_t      res,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [7:0]    cfg_data
);

	localparam int LOG_D  = $clog2(HISTORY_DEPTH);
	localparam int SUM_W  = 8 + LOG_D;
	localparam int K      = SUM_W + LOG_D;
	localparam int PROD_W = SUM_W + K;
	localparam logic [K-1:0] RECIP = K'(((1 << K) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

	logic [7:0] duty_limit_q;
	logic [7:0] soft_start_gap_q;
	logic [7:0] low_current_level_q;
	logic [7:0] soft_start_length_q;
	logic [7:0] target_limit_q;

	logic [7:0]       cur_hist_q [HISTORY_DEPTH];
	logic [7:0]       volt_hist_q [HISTORY_DEPTH];
	logic [SUM_W-1:0] cur_sum_q;
	logic [SUM_W-1:0] volt_sum_q;
	logic             expect_voltage_q;

	logic       v_s1, volt_s1, v_s2, volt_s2;
	logic [1:0] op_s1, op_s2;

	logic [7:0] current_mean_q;
	logic [7:0] voltage_mean_q;
	logic [7:0] duty_q;
	logic [7:0] target_q;
	logic [8:0] soft_count_q;

	logic          en;
	logic          take;
	logic          cur_take, volt_take;
	logic [SUM_W-1:0] sum_sel;
	logic [PROD_W-1:0] prod;
	logic [7:0]    mean_new;

	logic [7:0] duty_nx, duty_clamped, target_nx;
	logic [8:0] soft_count_nx;
	logic       changed_nx;
	logic [7:0] gap;

	assign en        = !res_valid || !res_stall;
	assign cmd_stall = !en;
	assign cfg_ready = 1'b1;
	assign take      = en && cmd_valid;
	assign cur_take  = take && (cmd.opcode == lcr_pkg::OP_SAMPLE) && !expect_voltage_q;
	assign volt_take = take && (cmd.opcode == lcr_pkg::OP_SAMPLE) && expect_voltage_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q        <= lcr_pkg::RST_DUTY_LIMIT;
			soft_start_gap_q    <= lcr_pkg::RST_SOFT_START_GAP;
			low_current_level_q <= lcr_pkg::RST_LOW_CURRENT_LEVEL;
			soft_start_length_q <= lcr_pkg::RST_SOFT_START_LENGTH;
			target_limit_q      <= lcr_pkg::RST_TARGET_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcr_pkg::CFG_DUTY_LIMIT:        duty_limit_q        <= cfg_data;
				lcr_pkg::CFG_SOFT_START_GAP:    soft_start_gap_q    <= cfg_data;
				lcr_pkg::CFG_LOW_CURRENT_LEVEL: low_current_level_q <= cfg_data;
				lcr_pkg::CFG_SOFT_START_LENGTH: soft_start_length_q <= cfg_data;
				lcr_pkg::CFG_TARGET_LIMIT:      target_limit_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: shift histories and update running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				cur_hist_q[i]  <= '0;
				volt_hist_q[i] <= '0;
			end
			cur_sum_q        <= '0;
			volt_sum_q       <= '0;
			expect_voltage_q <= 1'b0;
			v_s1             <= 1'b0;
			op_s1            <= lcr_pkg::OP_SAMPLE;
			volt_s1          <= 1'b0;
		end else if (en) begin
			v_s1    <= cmd_valid;
			op_s1   <= cmd.opcode;
			volt_s1 <= volt_take;
			if (cur_take) begin
				cur_hist_q[0] <= cmd.sample;
				for (int i = 1; i < HISTORY_DEPTH; i++) cur_hist_q[i] <= cur_hist_q[i-1];
				cur_sum_q <= cur_sum_q + SUM_W'(cmd.sample)
					- SUM_W'(cur_hist_q[HISTORY_DEPTH-1]);
				expect_voltage_q <= 1'b1;
			end
			if (volt_take) begin
				volt_hist_q[0] <= cmd.sample;
				for (int i = 1; i < HISTORY_DEPTH; i++) volt_hist_q[i] <= volt_hist_q[i-1];
				volt_sum_q <= volt_sum_q + SUM_W'(cmd.sample)
					- SUM_W'(volt_hist_q[HISTORY_DEPTH-1]);
				expect_voltage_q <= 1'b0;
			end
		end
	end

	// stage 2: floor mean by reciprocal multiply
	assign sum_sel  = volt_s1 ? volt_sum_q : cur_sum_q;
	assign prod     = PROD_W'(sum_sel) * PROD_W'(RECIP);
	assign mean_new = prod[K +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_mean_q <= '0;
			voltage_mean_q <= '0;
			v_s2           <= 1'b0;
			op_s2          <= lcr_pkg::OP_SAMPLE;
			volt_s2        <= 1'b0;
		end else if (en) begin
			v_s2    <= v_s1;
			op_s2   <= op_s1;
			volt_s2 <= volt_s1;
			if (v_s1 && (op_s1 == lcr_pkg::OP_SAMPLE)) begin
				if (volt_s1) voltage_mean_q <= mean_new;
				else         current_mean_q <= mean_new;
			end
		end
	end

	// stage 3: regulation, buttons, clamp
	assign gap = target_q - current_mean_q;

	always_comb begin
		duty_nx       = duty_q;
		target_nx     = target_q;
		soft_count_nx = soft_count_q;
		changed_nx    = 1'b0;
		case (op_s2)
			lcr_pkg::OP_SAMPLE: begin
				if (!volt_s2) begin
					if (current_mean_q < target_q) begin
						if (gap > soft_start_gap_q && current_mean_q < low_current_level_q) begin
							if (soft_count_q > {1'b0, soft_start_length_q}) begin
								duty_nx = 8'd1;
							end else begin
								if (duty_q < duty_limit_q) duty_nx = duty_q + 8'd1;
								soft_count_nx = soft_count_q + 9'd1;
							end
						end else if (duty_q < duty_limit_q) begin
							duty_nx = duty_q + 8'd1;
						end
					end else if (current_mean_q > target_q) begin
						if (duty_q != 8'd0) duty_nx = duty_q - 8'd1;
					end
				end
			end
			lcr_pkg::OP_INCREASE: begin
				if (target_q < target_limit_q) begin
					target_nx  = target_q + 8'd1;
					changed_nx = 1'b1;
				end
			end
			lcr_pkg::OP_DECREASE: begin
				if (target_q > 8'd1) begin
					target_nx  = target_q - 8'd1;
					changed_nx = 1'b1;
				end
			end
			default: ;
		endcase
		duty_clamped = (duty_nx > duty_limit_q) ? duty_limit_q : duty_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q       <= 8'd1;
			target_q     <= 8'd1;
			soft_count_q <= '0;
			res_valid    <= 1'b0;
		end else if (en) begin
			res_valid <= v_s2;
			if (v_s2) begin
				duty_q       <= duty_clamped;
				target_q     <= target_nx;
				soft_count_q <= soft_count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			res.duty               <= duty_clamped;
			res.target             <= target_nx;
			res.current_average    <= current_mean_q;
			res.voltage_average    <= voltage_mean_q;
			res.target_changed     <= changed_nx;
			res.sample_was_voltage <= volt_s2 && (op_s2 == lcr_pkg::OP_SAMPLE);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lcr_checker.sv
// ----------------------------------------------------------------------------
// lcr_checker
// Port-level checks of the LED current regulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          cmd_valid,
	input wire logic          cmd_stall,
	input wire lcr_pkg::cmd_t cmd,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire lcr_pkg::res_t res,
	input wire logic          cfg_valid,
	input wire logic          cfg_ready,
	input wire logic [2:0]    cfg_index,
	input wire logic [7:0]    cfg_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("command stalled without a blocked result");

	a_target_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.target != 8'd0)
		else $error("target reached zero");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.target_changed && res.sample_was_voltage))
		else $error("button change and voltage sample in one result");

endmodule

bind led_current_regulator lcr_checker u_lcr_checker (.*);

`default_nettype wire
